// ===== sv/gts_pkg.sv =====
// ----------------------------------------------------------------------------
// gts_pkg: shared types and constants for the GGA time sync block
// Phase codes, ASCII constants, configuration defaults and digit conversion.
// ----------------------------------------------------------------------------
package gts_pkg;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_LISTEN  = 2'd1,
        PH_SYNCED  = 2'd2,
        PH_STOPPED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CFG_WAIT_SECONDS = 2'd0,
        CFG_FAIL_LIMIT   = 2'd1,
        CFG_RETRY_LIMIT  = 2'd2,
        CFG_SENTENCE_TAG = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 40;

    localparam logic [5:0]  RST_WAIT_SECONDS = 6'd15;
    localparam logic [2:0]  RST_FAIL_LIMIT   = 3'd5;
    localparam logic [1:0]  RST_RETRY_LIMIT  = 2'd3;
    localparam logic [39:0] RST_SENTENCE_TAG = 40'h47_50_47_47_41;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam int TAG_LEN  = 5;
    localparam int TIME_LEN = 6;

    localparam logic [5:0] TAG_LAST_IDX = 6'(TAG_LEN - 1);
    localparam logic [5:0] TIME_LEN_IDX = 6'(TIME_LEN);
    localparam logic [5:0] IDX_MAX      = 6'd35;
    localparam logic [5:0] TICK_MAX     = 6'd63;
    localparam logic [2:0] FIX_FIELD    = 3'd6;
    localparam logic [2:0] LAST_COMMA   = 3'd7;

    // eleven times the ASCII zero bias, taken modulo 256
    localparam logic [7:0] DIGIT_BIAS = 8'((11 * 48) % 256);

    typedef struct packed {
        logic [5:0]  wait_seconds;
        logic [2:0]  fail_limit;
        logic [1:0]  retry_limit;
        logic [39:0] sentence_tag;
    } t_cfg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_phase     phase;
        logic       sync_pulse;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] secs;
        logic [5:0] wait_left;
        logic [2:0] fail_count;
        logic [1:0] retry_count;
    } t_result;

    function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] t;
        t = {hi[4:0], 3'b000} + {hi[6:0], 1'b0};
        return t + lo - DIGIT_BIAS;
    endfunction

endpackage

// ===== sv/gts_in_if.sv =====
// ----------------------------------------------------------------------------
// gts_in_if: input request channel
// Carries one command or received character per request.
// ----------------------------------------------------------------------------
interface gts_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== sv/gts_out_if.sv =====
// ----------------------------------------------------------------------------
// gts_out_if: result request channel
// Carries phase, captured time and counters for each input request.
// ----------------------------------------------------------------------------
interface gts_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] phase;
    logic       sync_pulse;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] secs;
    logic [5:0] wait_left;
    logic [2:0] fail_count;
    logic [1:0] retry_count;

    modport source (output valid, output phase, output sync_pulse, output hours,
                    output minutes, output secs, output wait_left, output fail_count,
                    output retry_count, input ready);
    modport sink   (input valid, input phase, input sync_pulse, input hours,
                    input minutes, input secs, input wait_left, input fail_count,
                    input retry_count, output ready);
endinterface

// ===== sv/gps_gga_time_sync_top.sv =====
// The core forms each result combinationally; the output register loads it when empty or read.
// Throughput: one request per cycle without output stalls, set by the single state update.
// If empty, the input register takes a new request while a finished result waits at the output.
// Reset (synchronous, active low) clears phase, counters and both stages, loads defaults.
// ----------------------------------------------------------------------------
// gps_gga_time_sync_top: GGA sentence time capture with wait and retry
// Waits for ticks, matches the sentence tag, captures time on a valid fix.
// ----------------------------------------------------------------------------
module gps_gga_time_sync_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [gts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gts_in_if.sink                         i_in,
    gts_out_if.source                      o_out
);

    gts_pkg::t_cfg    w_cfg;
    gts_pkg::t_item   w_item;
    gts_pkg::t_result w_result;
    logic             w_item_valid;
    logic             w_take;
    logic             w_en;

    assign w_en = w_item_valid && w_take;

    gts_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    gts_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    gts_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    gts_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_item_valid),
        .i_result (w_result),
        .o_take   (w_take),
        .o_out    (o_out)
    );

endmodule

// ===== sv/gts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gts_cfg_regs: configuration register file
// Holds wait time, failure and retry limits and the sentence tag.
// ----------------------------------------------------------------------------
module gts_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [gts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output gts_pkg::t_cfg                  o_cfg
);

    gts_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wait_seconds <= gts_pkg::RST_WAIT_SECONDS;
            r_cfg.fail_limit   <= gts_pkg::RST_FAIL_LIMIT;
            r_cfg.retry_limit  <= gts_pkg::RST_RETRY_LIMIT;
            r_cfg.sentence_tag <= gts_pkg::RST_SENTENCE_TAG;
        end else if (i_cfg_we) begin
            case (gts_pkg::t_cfg_idx'(i_cfg_idx))
                gts_pkg::CFG_WAIT_SECONDS: r_cfg.wait_seconds <= i_cfg_data[5:0];
                gts_pkg::CFG_FAIL_LIMIT:   r_cfg.fail_limit   <= i_cfg_data[2:0];
                gts_pkg::CFG_RETRY_LIMIT:  r_cfg.retry_limit  <= i_cfg_data[1:0];
                gts_pkg::CFG_SENTENCE_TAG: r_cfg.sentence_tag <= i_cfg_data[39:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/gts_in_stage.sv =====
// ----------------------------------------------------------------------------
// gts_in_stage: input register
// Captures one request and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module gts_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gts_in_if.sink         i_in,
    input  logic           i_take,
    output logic           o_valid,
    output gts_pkg::t_item o_item
);

    logic           r_valid;
    gts_pkg::t_item r_item;
    logic           w_advance;
    logic           w_load;

    assign w_advance  = r_valid && i_take;
    assign i_in.ready = !r_valid || w_advance;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (w_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd     <= i_in.cmd;
            r_item.rx_byte <= i_in.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/gts_core.sv =====
// ----------------------------------------------------------------------------
// gts_core: sentence tracking state and per-request update
// Applies one tick or character to the sync state and forms its result.
// ----------------------------------------------------------------------------
module gts_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  gts_pkg::t_item   i_item,
    input  gts_pkg::t_cfg    i_cfg,
    output gts_pkg::t_result o_result
);

    gts_pkg::t_phase r_phase,       n_phase;
    logic [5:0]      r_tick_count,  n_tick_count;
    logic            r_tag_check,   n_tag_check;
    logic            r_recording,   n_recording;
    logic [5:0]      r_char_index,  n_char_index;
    logic [2:0]      r_comma_count, n_comma_count;
    logic            r_fix_valid,   n_fix_valid;
    logic [2:0]      r_fails,       n_fails;
    logic [1:0]      r_retries,     n_retries;
    logic [7:0]      r_tag_chars  [gts_pkg::TAG_LEN-1];
    logic [7:0]      n_tag_chars  [gts_pkg::TAG_LEN-1];
    logic [7:0]      r_time_chars [gts_pkg::TIME_LEN];
    logic [7:0]      n_time_chars [gts_pkg::TIME_LEN];

    logic       w_pulse;
    logic       w_match;
    logic [2:0] w_cc_inc;
    logic [2:0] w_fails_inc;
    logic [1:0] w_retries_inc;
    logic [7:0] w_c;

    assign w_c           = i_item.rx_byte;
    assign w_cc_inc      = r_comma_count + 3'd1;
    assign w_fails_inc   = r_fails + 3'd1;
    assign w_retries_inc = r_retries + 2'd1;

    always_comb begin
        w_match = (w_c == i_cfg.sentence_tag[7:0]);
        for (int k = 0; k < gts_pkg::TAG_LEN - 1; k++) begin
            if (r_tag_chars[k] != i_cfg.sentence_tag[39 - 8 * k -: 8]) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_tick_count  = r_tick_count;
        n_tag_check   = r_tag_check;
        n_recording   = r_recording;
        n_char_index  = r_char_index;
        n_comma_count = r_comma_count;
        n_fix_valid   = r_fix_valid;
        n_fails       = r_fails;
        n_retries     = r_retries;
        n_tag_chars   = r_tag_chars;
        n_time_chars  = r_time_chars;
        w_pulse       = 1'b0;

        if (i_item.cmd) begin
            if (r_phase == gts_pkg::PH_WAIT) begin
                if (r_tick_count < gts_pkg::TICK_MAX) begin
                    n_tick_count = r_tick_count + 6'd1;
                end
                if (n_tick_count >= i_cfg.wait_seconds) begin
                    n_phase = gts_pkg::PH_LISTEN;
                end
            end
        end else if (r_phase == gts_pkg::PH_LISTEN) begin
            if (r_recording) begin
                if (w_c == gts_pkg::CH_COMMA) begin
                    if (r_comma_count != 3'd0) begin
                        if (r_char_index < gts_pkg::TIME_LEN_IDX) begin
                            n_time_chars[r_char_index[2:0]] = w_c;
                        end
                        if (r_char_index < gts_pkg::IDX_MAX) begin
                            n_char_index = r_char_index + 6'd1;
                        end
                    end
                    n_comma_count = w_cc_inc;
                    if (w_cc_inc == gts_pkg::LAST_COMMA) begin
                        n_comma_count = 3'd0;
                        if (r_fix_valid) begin
                            n_phase = gts_pkg::PH_SYNCED;
                            w_pulse = 1'b1;
                        end else begin
                            n_recording  = 1'b0;
                            n_tag_check  = 1'b0;
                            n_char_index = 6'd0;
                            n_fails      = w_fails_inc;
                            if (w_fails_inc == i_cfg.fail_limit) begin
                                n_retries    = w_retries_inc;
                                n_tick_count = 6'd0;
                                n_fails      = 3'd0;
                                n_phase      = (w_retries_inc == i_cfg.retry_limit)
                                             ? gts_pkg::PH_STOPPED : gts_pkg::PH_WAIT;
                            end
                        end
                    end
                end else if (w_c == gts_pkg::CH_SPACE) begin
                    n_recording = r_recording;
                end else if (r_comma_count == gts_pkg::FIX_FIELD) begin
                    n_fix_valid = (w_c == gts_pkg::CH_ONE) || (w_c == gts_pkg::CH_TWO)
                               || (w_c == gts_pkg::CH_THREE);
                end else begin
                    if (r_char_index < gts_pkg::TIME_LEN_IDX) begin
                        n_time_chars[r_char_index[2:0]] = w_c;
                    end
                    if (r_char_index < gts_pkg::IDX_MAX) begin
                        n_char_index = r_char_index + 6'd1;
                    end
                end
            end else if (r_tag_check && (r_char_index <= gts_pkg::TAG_LAST_IDX)) begin
                if (r_char_index == gts_pkg::TAG_LAST_IDX) begin
                    n_tag_check  = 1'b0;
                    n_char_index = 6'd0;
                    n_recording  = w_match;
                end else begin
                    n_tag_chars[r_char_index[1:0]] = w_c;
                    n_char_index = r_char_index + 6'd1;
                end
            end else if ((w_c == gts_pkg::CH_DOLLAR) && !r_tag_check) begin
                n_tag_check = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.phase       = n_phase;
        o_result.sync_pulse  = w_pulse;
        o_result.hours       = 8'd0;
        o_result.minutes     = 8'd0;
        o_result.secs        = 8'd0;
        if (n_phase == gts_pkg::PH_SYNCED) begin
            o_result.hours   = gts_pkg::two_digits(n_time_chars[0], n_time_chars[1]);
            o_result.minutes = gts_pkg::two_digits(n_time_chars[2], n_time_chars[3]);
            o_result.secs    = gts_pkg::two_digits(n_time_chars[4], n_time_chars[5]);
        end
        o_result.wait_left   = (n_tick_count >= i_cfg.wait_seconds)
                             ? 6'd0 : (i_cfg.wait_seconds - n_tick_count);
        o_result.fail_count  = n_fails;
        o_result.retry_count = n_retries;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= gts_pkg::PH_WAIT;
            r_tick_count  <= 6'd0;
            r_tag_check   <= 1'b0;
            r_recording   <= 1'b0;
            r_char_index  <= 6'd0;
            r_comma_count <= 3'd0;
            r_fix_valid   <= 1'b0;
            r_fails       <= 3'd0;
            r_retries     <= 2'd0;
            for (int k = 0; k < gts_pkg::TIME_LEN; k++) begin
                r_time_chars[k] <= 8'd0;
            end
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_tick_count  <= n_tick_count;
            r_tag_check   <= n_tag_check;
            r_recording   <= n_recording;
            r_char_index  <= n_char_index;
            r_comma_count <= n_comma_count;
            r_fix_valid   <= n_fix_valid;
            r_fails       <= n_fails;
            r_retries     <= n_retries;
            r_time_chars  <= n_time_chars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_chars <= n_tag_chars;
        end
    end

endmodule

// ===== sv/gts_out_stage.sv =====
// ----------------------------------------------------------------------------
// gts_out_stage: result register
// Holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module gts_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gts_pkg::t_result i_result,
    output logic             o_take,
    gts_out_if.source        o_out
);

    logic             r_valid;
    gts_pkg::t_result r_result;

    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_take) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.phase       = r_result.phase;
    assign o_out.sync_pulse  = r_result.sync_pulse;
    assign o_out.hours       = r_result.hours;
    assign o_out.minutes     = r_result.minutes;
    assign o_out.secs        = r_result.secs;
    assign o_out.wait_left   = r_result.wait_left;
    assign o_out.fail_count  = r_result.fail_count;
    assign o_out.retry_count = r_result.retry_count;

endmodule

// ===== test/gps_gga_time_sync_top_test.sv =====
// ----------------------------------------------------------------------------
// gps_gga_time_sync_top_test: self-checking bench for the GGA time sync block
// Drives ticks and receiver characters through the request channel, with
// burst/gap pacing on the sender and a rotating stall pattern on the result
// side. A tracker class mirrors the wait/listen/sync/stop behaviour and checks
// every result in order. A second tracker instance plans the stimulus, so most
// traffic is well-formed sentences that walk the fail/retry loop, with noise,
// wrong tags and cut-off sentences mixed in, and the run ends in sync or stop.
// ----------------------------------------------------------------------------
module gps_gga_time_sync_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gts_pkg::*;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam int ACTED_TARGET = 750;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    class gga_sync_tracker;
        logic [5:0]  wait_secs;
        logic [2:0]  fail_limit;
        logic [1:0]  retry_limit;
        logic [39:0] tag_word;

        t_phase      phase;
        logic [5:0]  ticks;
        bit          tag_armed;
        bit          capturing;
        logic [5:0]  idx;
        logic [2:0]  commas;
        bit          fix_ok;
        logic [2:0]  fails;
        logic [1:0]  retries;
        logic [7:0]  tag_seen[TAG_LEN];
        logic [7:0]  time_digits[TIME_LEN];

        t_result     awaited[$];
        int          noted;
        int          checked;
        int          mismatches;
        int          syncs;

        function new();
            wait_secs   = RST_WAIT_SECONDS;
            fail_limit  = RST_FAIL_LIMIT;
            retry_limit = RST_RETRY_LIMIT;
            tag_word    = RST_SENTENCE_TAG;
            phase       = PH_WAIT;
            ticks       = '0;
            tag_armed   = 1'b0;
            capturing   = 1'b0;
            idx         = '0;
            commas      = '0;
            fix_ok      = 1'b0;
            fails       = '0;
            retries     = '0;
            foreach (tag_seen[k]) tag_seen[k] = '0;
            foreach (time_digits[k]) time_digits[k] = '0;
            noted      = 0;
            checked    = 0;
            mismatches = 0;
            syncs      = 0;
        endfunction

        function void set_register(t_cfg_idx sel, logic [39:0] value);
            case (sel)
                CFG_WAIT_SECONDS: wait_secs = value[5:0];
                CFG_FAIL_LIMIT:   fail_limit = value[2:0];
                CFG_RETRY_LIMIT:  retry_limit = value[1:0];
                CFG_SENTENCE_TAG: tag_word = value;
                default: ;
            endcase
        endfunction

        function void keep_char(logic [7:0] c);
            if (idx < TIME_LEN_IDX) time_digits[idx] = c;
            if (idx < IDX_MAX) idx = idx + 6'd1;
        endfunction

        function logic [7:0] digit_pair(logic [7:0] hi, logic [7:0] lo);
            int v;
            v = (int'(hi) - int'(CH_ZERO)) * 10 + (int'(lo) - int'(CH_ZERO));
            return v[7:0];
        endfunction

        function void note_request(t_item req);
            t_result    res;
            bit         pulse;
            logic [7:0] c;
            pulse = 1'b0;
            c = req.rx_byte;
            noted++;
            if (req.cmd == CMD_TICK) begin
                if (phase == PH_WAIT) begin
                    if (ticks < TICK_MAX) ticks = ticks + 6'd1;
                    if (ticks >= wait_secs) phase = PH_LISTEN;
                end
            end else if (phase == PH_LISTEN) begin
                if (capturing) begin
                    if (c == CH_COMMA) begin
                        if (commas != 3'd0) keep_char(c);
                        commas = commas + 3'd1;
                        if (commas == LAST_COMMA) begin
                            commas = 3'd0;
                            if (fix_ok) begin
                                phase = PH_SYNCED;
                                pulse = 1'b1;
                            end else begin
                                capturing = 1'b0;
                                tag_armed = 1'b0;
                                idx = '0;
                                fails = fails + 3'd1;
                                if (fails == fail_limit) begin
                                    retries = retries + 2'd1;
                                    ticks = '0;
                                    fails = '0;
                                    phase = (retries == retry_limit) ? PH_STOPPED : PH_WAIT;
                                end
                            end
                        end
                    end else if (c != CH_SPACE) begin
                        if (commas == FIX_FIELD)
                            fix_ok = (c == CH_ONE || c == CH_TWO || c == CH_THREE);
                        else
                            keep_char(c);
                    end
                end else if (tag_armed && idx < TAG_LEN) begin
                    tag_seen[idx] = c;
                    idx = idx + 6'd1;
                    if (idx == TAG_LEN) begin
                        tag_armed = 1'b0;
                        idx = '0;
                        capturing = (tag_word == {tag_seen[0], tag_seen[1], tag_seen[2],
                                                  tag_seen[3], tag_seen[4]});
                    end
                end else if (c == CH_DOLLAR && !tag_armed) begin
                    tag_armed = 1'b1;
                end
            end

            res.phase      = phase;
            res.sync_pulse = pulse;
            if (phase == PH_SYNCED) begin
                res.hours   = digit_pair(time_digits[0], time_digits[1]);
                res.minutes = digit_pair(time_digits[2], time_digits[3]);
                res.secs    = digit_pair(time_digits[4], time_digits[5]);
            end else begin
                res.hours   = '0;
                res.minutes = '0;
                res.secs    = '0;
            end
            res.wait_left   = (ticks >= wait_secs) ? 6'd0 : wait_secs - ticks;
            res.fail_count  = fails;
            res.retry_count = retries;
            if (pulse) syncs++;
            awaited.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with nothing awaited: phase %0d pulse %0d",
                             $realtime, got.phase, got.sync_pulse);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.phase !== want.phase || got.sync_pulse !== want.sync_pulse ||
                got.hours !== want.hours || got.minutes !== want.minutes ||
                got.secs !== want.secs || got.wait_left !== want.wait_left ||
                got.fail_count !== want.fail_count || got.retry_count !== want.retry_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] result %0d mismatch", $realtime, checked);
                    $display("  expected ph %0d pulse %0d time %0d:%0d:%0d left %0d fails %0d retries %0d",
                             want.phase, want.sync_pulse, want.hours, want.minutes, want.secs,
                             want.wait_left, want.fail_count, want.retry_count);
                    $display("  actual   ph %0d pulse %0d time %0d:%0d:%0d left %0d fails %0d retries %0d",
                             got.phase, got.sync_pulse, got.hours, got.minutes, got.secs,
                             got.wait_left, got.fail_count, got.retry_count);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gts_in_if  in_ch();
    gts_out_if out_ch();

    gps_gga_time_sync_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    gga_sync_tracker tracker;
    gga_sync_tracker planner;
    t_item           char_feed[$];
    int              acted_on;
    int              sentences;
    int              settings_used;
    int              idle_cycles;
    bit              fix_allowed;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                t_item req;
                req.cmd     = in_ch.cmd;
                req.rx_byte = in_ch.rx_byte;
                tracker.note_request(req);
            end
            if (out_ch.valid && out_ch.ready) begin
                t_result got;
                got.phase       = t_phase'(out_ch.phase);
                got.sync_pulse  = out_ch.sync_pulse;
                got.hours       = out_ch.hours;
                got.minutes     = out_ch.minutes;
                got.secs        = out_ch.secs;
                got.wait_left   = out_ch.wait_left;
                got.fail_count  = out_ch.fail_count;
                got.retry_count = out_ch.retry_count;
                tracker.check_result(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no request moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("** gps_gga_time_sync_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] pattern;
        out_ch.ready <= 1'b0;
        pattern = '1;
        forever begin
            for (int b = 0; b < 16; b++) begin
                @(negedge i_clk);
                out_ch.ready <= pattern[b];
            end
            case ($urandom_range(0, 3))
                0: pattern = '1;
                1: pattern = 16'($urandom | $urandom);
                default: pattern = 16'($urandom);
            endcase
        end
    end

    function automatic void add_request(logic cmd, logic [7:0] b);
        t_item req;
        if (cmd == CMD_BYTE && !fix_allowed && planner.phase == PH_LISTEN &&
            planner.capturing && planner.commas == FIX_FIELD &&
            (b == CH_ONE || b == CH_TWO || b == CH_THREE))
            b = CH_ZERO;
        if ((cmd == CMD_TICK && planner.phase == PH_WAIT) ||
            (cmd == CMD_BYTE && planner.phase == PH_LISTEN))
            acted_on++;
        req.cmd     = cmd;
        req.rx_byte = b;
        planner.note_request(req);
        planner.awaited.delete();
        char_feed.push_back(req);
    endfunction

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++) add_request(CMD_BYTE, s[k]);
    endfunction

    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: c = 8'($urandom_range(0, 255));
            1: c = CH_SPACE;
            2: c = CH_DOLLAR;
            3: c = 8'($urandom_range(8'h41, 8'h5A));
            default: c = 8'(int'(CH_ZERO) + $urandom_range(0, 9));
        endcase
        if (c == CH_COMMA) c = CH_ZERO;
        return c;
    endfunction

    // keep < 0 sends the whole sentence, otherwise it is cut after keep characters
    function automatic void add_sentence(bit good_tag, bit fix_wanted, int keep);
        logic [7:0] line[$];
        logic [7:0] c;
        int         bad;
        int         n;
        bad = good_tag ? -1 : $urandom_range(0, TAG_LEN - 1);
        sentences++;
        line.push_back(CH_DOLLAR);
        for (int k = 0; k < TAG_LEN; k++) begin
            c = planner.tag_word[39 - 8 * k -: 8];
            if (k == bad) c = c ^ 8'($urandom_range(1, 255));
            line.push_back(c);
        end
        line.push_back(CH_COMMA);
        if ($urandom_range(0, 15) == 0)
            n = $urandom_range(30, 45);
        else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, 9);
        else
            n = TIME_LEN;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) line.push_back(CH_SPACE);
            if ($urandom_range(0, 7) == 0)
                line.push_back(filler_char());
            else
                line.push_back(8'(int'(CH_ZERO) + $urandom_range(0, 9)));
        end
        for (int f = 0; f < 4; f++) begin
            line.push_back(CH_COMMA);
            repeat ($urandom_range(0, 3)) line.push_back(filler_char());
        end
        line.push_back(CH_COMMA);
        repeat ($urandom_range(0, 2)) line.push_back(filler_char());
        if (fix_wanted)
            c = 8'(int'(CH_ONE) + $urandom_range(0, 2));
        else if ($urandom_range(0, 1) == 0)
            c = CH_ZERO;
        else
            c = 8'($urandom_range(int'(CH_THREE) + 1, 255));
        line.push_back(c);
        line.push_back(CH_COMMA);
        if (keep < 0 || keep > line.size()) keep = line.size();
        for (int k = 0; k < keep; k++) add_request(CMD_BYTE, line[k]);
    endfunction

    task automatic run_requests();
        t_item req;
        int    burst;
        int    gap;
        burst = $urandom_range(1, 16);
        while (char_feed.size() != 0) begin
            req = char_feed.pop_front();
            @(negedge i_clk);
            in_ch.valid   <= 1'b1;
            in_ch.cmd     <= req.cmd;
            in_ch.rx_byte <= req.rx_byte;
            do @(posedge i_clk); while (!in_ch.ready);
            burst--;
            if (burst <= 0) begin
                burst = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    @(negedge i_clk);
                    in_ch.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx sel, logic [39:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= value;
        tracker.set_register(sel, value);
        planner.set_register(sel, value);
    endtask

    task automatic apply_settings(logic [5:0] ws, logic [2:0] mf, logic [1:0] mr,
                                  logic [39:0] tag);
        write_register(CFG_WAIT_SECONDS, 40'(ws));
        write_register(CFG_FAIL_LIMIT, 40'(mf));
        write_register(CFG_RETRY_LIMIT, 40'(mr));
        write_register(CFG_SENTENCE_TAG, tag);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_round(int round_no);
        logic [5:0]  ws;
        logic [2:0]  mf;
        logic [1:0]  mr;
        logic [1:0]  next_retry;
        logic [39:0] tag;
        int          goal;
        next_retry = planner.retries + 2'd1;
        if (round_no == 0) begin
            ws  = TICK_MAX;
            mf  = 3'd7;
            mr  = 2'd3;
            tag = '1;
        end else if (round_no == 1) begin
            ws  = 6'd1;
            mf  = 3'd1;
            mr  = 2'd1;
            tag = '0;
        end else begin
            case ($urandom_range(0, 9))
                0: ws = 6'd0;
                1: ws = TICK_MAX;
                default: ws = 6'($urandom_range(1, 6));
            endcase
            mf = 3'($urandom_range(0, 7));
            mr = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: tag = 40'({$urandom, $urandom});
                1: tag = RST_SENTENCE_TAG;
                default: tag = {8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h41, 8'h5A)),
                                8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h41, 8'h5A)),
                                8'($urandom_range(8'h41, 8'h5A))};
            endcase
        end
        // keep clear of the stop until the closing round
        if (mr == next_retry) mr = mr + 2'd1;
        apply_settings(ws, mf, mr, tag);
        goal = acted_on + $urandom_range(40, 200);
        while (acted_on < goal && planner.retries != next_retry) begin
            if (planner.phase == PH_WAIT) begin
                if ($urandom_range(0, 4) == 0)
                    add_request(CMD_BYTE, 8'($urandom_range(0, 255)));
                else
                    add_request(CMD_TICK, 8'($urandom_range(0, 255)));
            end else if (planner.phase == PH_LISTEN) begin
                case ($urandom_range(0, 9))
                    0: add_sentence(1'b0, 1'b0, -1);
                    1: add_sentence(1'b1, 1'b0, $urandom_range(1, 20));
                    2: repeat ($urandom_range(1, 6))
                        add_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    default: add_sentence(1'b1, 1'b0, -1);
                endcase
            end else begin
                break;
            end
        end
        run_requests();
    endtask

    task automatic closing_round();
        bit         to_stop;
        logic [1:0] mr;
        to_stop = ($urandom_range(0, 3) == 0);
        mr = planner.retries + 2'd1;
        if (to_stop) begin
            apply_settings(6'($urandom_range(1, 4)), 3'd1, mr, planner.tag_word);
        end else begin
            // hold the fail limit at the current count so no retry can interfere
            apply_settings(6'($urandom_range(1, 4)), planner.fails, mr + 2'd1,
                           planner.tag_word);
        end
        fix_allowed = !to_stop;
        while (planner.phase != PH_SYNCED && planner.phase != PH_STOPPED) begin
            if (planner.phase == PH_WAIT)
                add_request(CMD_TICK, 8'($urandom_range(0, 255)));
            else
                add_sentence(1'b1, !to_stop, -1);
        end
        repeat (8) add_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        run_requests();
    endtask

    initial begin
        int round_no;
        tracker = new();
        planner = new();
        acted_on = 0;
        sentences = 0;
        settings_used = 0;
        idle_cycles = 0;
        fix_allowed = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_WAIT_SECONDS;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= CMD_BYTE;
        in_ch.rx_byte <= '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: bytes ignored while waiting, ticks count down
        add_request(CMD_BYTE, 8'h00);
        add_request(CMD_BYTE, 8'hFF);
        add_request(CMD_TICK, 8'hA5);
        add_request(CMD_TICK, 8'h5A);
        run_requests();
        // zero wait takes effect at once and ends the wait on the next tick
        write_register(CFG_WAIT_SECONDS, 40'd0);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        add_request(CMD_TICK, 8'h00);
        add_request(CMD_TICK, 8'hFF);
        fix_allowed = 1'b1;
        add_text("$GPGGA, 1 23456,A,,B C,D,2 9,");
        add_text("$GPGGB,123456,,,,,1,");
        add_text("$GP$GPGGA,235959,,,,,0,");
        add_text("$GPGGA,125959,x,y,z,w,,");
        fix_allowed = 1'b0;
        run_requests();

        round_no = 0;
        while (acted_on < ACTED_TARGET) begin
            random_round(round_no);
            round_no++;
        end
        closing_round();

        $display("Covered %0d requests (%0d acted on), %0d sentences, %0d settings.",
                 tracker.noted, acted_on, sentences, settings_used);
        $display("Checked %0d results; closing phase %s, sync pulses %0d, mismatches %0d.",
                 tracker.checked, tracker.phase.name(), tracker.syncs, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("** gps_gga_time_sync_top: PASSED **");
        else
            $display("** gps_gga_time_sync_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gts_pkg.sv
sv/gts_in_if.sv
sv/gts_out_if.sv
sv/gts_cfg_regs.sv
sv/gts_in_stage.sv
sv/gts_core.sv
sv/gts_out_stage.sv
sv/gps_gga_time_sync_top.sv
test/gps_gga_time_sync_top_test.sv
